[hw/rtl/b2da_pkg.sv]
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter:
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

    // Width of one output character and the code of '0'
    localparam int unsigned CHAR_W = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Width of one BCD digit and the add-3 threshold of double dabble
    localparam int unsigned BCD_W = 4;
    localparam logic [BCD_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [BCD_W-1:0] BCD_ADJ_ADD = 4'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture a new value, clear BCD, preset counters
        logic step;     // one double-dabble shift/adjust step
        logic advance;  // shift the digit window up by one digit
        logic emit;     // drive the top digit out as a result transfer
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic bits_done;  // final conversion step is in progress
        logic top_zero;   // top of the window and every digit above it are zero
        logic cnt_zero;   // top of the window is the least significant digit
    } status_t;

endpackage : b2da_pkg

`default_nettype wire

[hw/rtl/b2da_datapath.sv]
// ----------------------------------------------------------------------------
// b2da_datapath
// Double-dabble binary to BCD converter, one input bit per cycle, followed
// by a digit window that shifts out one digit per cycle, most significant
// first, with a registered result output.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_datapath #(
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned MAX_DIGITS = 10
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire [VALUE_BITS-1:0]             value,
    input  b2da_pkg::cmd_t                   cmd,
    output b2da_pkg::status_t                status,
    output logic                             digit_valid,
    output logic [b2da_pkg::CHAR_W-1:0]      digit_char,
    output logic                             last_digit
);

    // Decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1
    localparam int unsigned BCD_DIGITS = (VALUE_BITS * 301) / 1000 + 1;
    // Digits kept for output and the counter that walks them
    localparam int unsigned KEEP = (BCD_DIGITS < MAX_DIGITS) ? BCD_DIGITS : MAX_DIGITS;
    localparam int unsigned CNT_W = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam int unsigned BIT_CNT_W = $clog2(VALUE_BITS);

    localparam int unsigned BCD_W = b2da_pkg::BCD_W;

    logic [VALUE_BITS-1:0] bin_reg;
    logic [BCD_W-1:0]      bcd_reg  [BCD_DIGITS];
    logic [BCD_W-1:0]      bcd_adj  [BCD_DIGITS];
    logic [BCD_W-1:0]      bcd_next [BCD_DIGITS];
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [CNT_W-1:0]      dig_cnt_reg;
    logic                  digit_valid_reg;
    logic [b2da_pkg::CHAR_W-1:0] digit_char_reg;
    logic                  last_digit_reg;
    logic                  top_zero;

    // Add 3 to every digit of five or more, then shift in the next input bit
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i] >= b2da_pkg::BCD_ADJ_MIN)
            begin
                bcd_adj[i] = bcd_reg[i] + b2da_pkg::BCD_ADJ_ADD;
            end
            else
            begin
                bcd_adj[i] = bcd_reg[i];
            end
        end
        bcd_next[0] = {bcd_adj[0][BCD_W-2:0], bin_reg[VALUE_BITS-1]};
        for (int i = 1; i < BCD_DIGITS; i++)
        begin
            bcd_next[i] = {bcd_adj[i][BCD_W-2:0], bcd_adj[i-1][BCD_W-1]};
        end
    end

    // Hold the binary value and the BCD digits
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= value;
            for (int i = 0; i < BCD_DIGITS; i++)
            begin
                bcd_reg[i] <= '0;
            end
        end
        else if (cmd.step)
        begin
            bin_reg <= {bin_reg[VALUE_BITS-2:0], 1'b0};
            for (int i = 0; i < BCD_DIGITS; i++)
            begin
                bcd_reg[i] <= bcd_next[i];
            end
        end
        else if (cmd.advance)
        begin
            // Move the next lower digit to the top of the window
            for (int i = BCD_DIGITS - 1; i > 0; i--)
            begin
                bcd_reg[i] <= bcd_reg[i-1];
            end
            bcd_reg[0] <= '0;
        end
    end

    // Count conversion steps and digits left in the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            bit_cnt_reg <= BIT_CNT_W'(VALUE_BITS - 1);
            dig_cnt_reg <= CNT_W'(KEEP - 1);
        end
        else
        begin
            if (cmd.step && bit_cnt_reg != '0)
            begin
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
            end
            if (cmd.advance && dig_cnt_reg != '0)
            begin
                dig_cnt_reg <= dig_cnt_reg - 1'b1;
            end
        end
    end

    // Register the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_valid_reg <= 1'b0;
        end
        else
        begin
            digit_valid_reg <= cmd.emit;
        end
    end

    // Register the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            digit_char_reg <= b2da_pkg::ASCII_ZERO
                              + {{(b2da_pkg::CHAR_W - BCD_W){1'b0}}, bcd_reg[KEEP-1]};
            last_digit_reg <= (dig_cnt_reg == '0);
        end
    end

    // Treat the window top as a leading zero only if no digit above the window is set
    always_comb
    begin
        top_zero = (bcd_reg[KEEP-1] == '0);
        for (int i = KEEP; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i] != '0)
            begin
                top_zero = 1'b0;
            end
        end
    end

    assign status.bits_done = (bit_cnt_reg == '0);
    assign status.top_zero  = top_zero;
    assign status.cnt_zero  = (dig_cnt_reg == '0);

    assign digit_valid = digit_valid_reg;
    assign digit_char  = digit_char_reg;
    assign last_digit  = last_digit_reg;

endmodule : b2da_datapath

`default_nettype wire

[hw/rtl/b2da_ctrl.sv]
// ----------------------------------------------------------------------------
// b2da_ctrl
// Controller: accepts a start, sequences the bit-serial conversion, skips
// leading zero digits and issues one result transfer per remaining digit.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  b2da_pkg::status_t  status,
    output b2da_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   lead_reg;
    logic   lead_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        lead_next   = lead_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.step = 1'b1;
                if (status.bits_done)
                begin
                    lead_next  = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.advance = 1'b1;
                // Drop leading zeros, but always keep the final digit
                if (!(lead_reg && status.top_zero && !status.cnt_zero))
                begin
                    cmd.emit  = 1'b1;
                    lead_next = 1'b0;
                    if (status.cnt_zero)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lead_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lead_reg  <= lead_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule : b2da_ctrl

`default_nettype wire

[hw/rtl/binary_to_decimal_ascii_top.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Converts an unsigned binary value to decimal ASCII digits, most
// significant digit first, one result transfer per digit.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive value and raise start; the value is taken at the clock edge
//   where start is high and busy is low. busy stays high until the last
//   digit has been issued.
//   Output: each digit appears on digit_char for one cycle with digit_valid
//   high; last_digit marks the least significant digit. The receiver cannot
//   stall, so it must take every digit in the cycle it is shown.
//   Leading zeros are suppressed; zero gives a single '0'. Only the
//   MAX_DIGITS least significant digits are issued.
// Timing:
//   Bit-serial double dabble over the VALUE_BITS input bits, then one cycle per digit
//   position in the output window (min(digits of VALUE_BITS, MAX_DIGITS)),
//   leading zeros included. A new value is taken only once the last digit
//   has been issued; each digit is registered and appears in the cycle after
//   its window slot is reached.
// Reset:
//   rst_n returns the controller to idle and drops digit_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_top #(
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned MAX_DIGITS = 10
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire [VALUE_BITS-1:0]             value,
    output logic                             digit_valid,
    output logic [b2da_pkg::CHAR_W-1:0]      digit_char,
    output logic                             last_digit
);

    b2da_pkg::cmd_t    cmd;
    b2da_pkg::status_t status;

    // Sequence the conversion and the digit transfers
    b2da_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Convert to BCD and shift the digits out
    b2da_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .digit_valid (digit_valid),
        .digit_char  (digit_char),
        .last_digit  (last_digit)
    );

endmodule : binary_to_decimal_ascii_top

`default_nettype wire

[sim/binary_to_decimal_ascii_top_tb.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top_tb
// Self-checking bench for the binary to decimal ASCII converter. Each value
// the block accepts is expanded into its expected digit stream: most
// significant digit first, no leading zeros, a single '0' for zero, and the
// last-digit flag on the final character. Every digit strobe is checked
// against the oldest pending digit. Stimulus opens with edge values, then
// runs random values shaped toward small numbers, powers of ten and short
// bit lengths, with random sender gaps except in the closing stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CHAR_W       = b2da_pkg::CHAR_W;
    localparam int unsigned VALUE_BITS   = 32;
    localparam int unsigned MAX_DIGITS   = 10;
    localparam int unsigned RADIX        = 10;
    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned RESET_CYCLES = 10;
    localparam int unsigned RANDOM_ITEMS = 350;
    localparam int unsigned STEADY_ITEMS = 60;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned MAX_REPORTS  = 40;
    localparam int unsigned RUN_LIMIT_NS = 3_000_000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_t;

    // Pending digits for every accepted value, and mismatch count
    class digit_scoreboard;
        digit_t expected_digits[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns mismatch: %s", $time, msg);
        endtask

        function int pending();
            return expected_digits.size();
        endfunction

        // Expand one accepted value into its digit characters
        function void note_value(logic [VALUE_BITS-1:0] v);
            int unsigned            dec[$];
            logic [VALUE_BITS-1:0]  rest;
            int                     keep;
            digit_t                 d;
            rest = v;
            if (rest == '0)
                dec.push_back(0);
            while (rest != '0)
            begin
                dec.push_back(int'(rest % RADIX));
                rest = rest / RADIX;
            end
            keep = (dec.size() > MAX_DIGITS) ? MAX_DIGITS : dec.size();
            // Most significant kept digit goes out first
            for (int k = keep - 1; k >= 0; k--)
            begin
                d.ch   = b2da_pkg::ASCII_ZERO + CHAR_W'(dec[k]);
                d.last = (k == 0);
                expected_digits.push_back(d);
            end
        endfunction

        // Compare one digit transfer with the oldest pending digit
        task check_digit(logic [CHAR_W-1:0] ch, logic last);
            digit_t d;
            if (expected_digits.size() == 0)
            begin
                report($sformatf("digit '%0d' last=%0b with nothing pending", ch, last));
            end
            else
            begin
                d = expected_digits.pop_front();
                if (ch !== d.ch)
                    report($sformatf("digit_char %0d, expected %0d", ch, d.ch));
                if (last !== d.last)
                    report($sformatf("last_digit %0b, expected %0b", last, d.last));
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [VALUE_BITS-1:0]  value;
    logic                   digit_valid;
    logic [CHAR_W-1:0]      digit_char;
    logic                   last_digit;

    digit_scoreboard sb;

    binary_to_decimal_ascii_top #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .digit_valid (digit_valid),
        .digit_char  (digit_char),
        .last_digit  (last_digit)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop if the run hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("binary_to_decimal_ascii_top_tb NOT OK");
        $finish;
    end

    // Note accepted values and check digit transfers at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_value(value);
            if (digit_valid !== 1'b0)
                sb.check_digit(digit_char, last_digit);
        end
    end

    // Present one value and hold it until the block takes it
    task send_value(logic [VALUE_BITS-1:0] v);
        logic taken;
        start = 1'b1;
        value = v;
        do
        begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
        while (!taken);
    endtask

    // Drop start for a burst of cycles, with noise on the value bus
    task idle_burst();
        int unsigned n;
        n = $urandom_range(1, 19);
        start = 1'b0;
        repeat (n)
        begin
            value = $urandom;
            @(negedge clk);
        end
    endtask

    // Hold off until every pending digit has come out
    task wait_drained();
        start = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Random value biased toward digit-count edges and short numbers
    function logic [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] p;
        int unsigned           n;
        p = 1;
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 99);
            1:
            begin
                n = $urandom_range(0, 9);
                repeat (n) p = p * RADIX;
                return p + $urandom_range(0, 2) - 1;
            end
            2: return $urandom >> $urandom_range(0, 31);
            3: return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [VALUE_BITS-1:0] edge_values[$];

        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero, digit-count boundaries, extremes, bit patterns
        edge_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
                        32'd999_999_999, 32'd1_000_000_000, 32'd1_000_000,
                        32'd1_234_567_890, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
                        32'hAAAA_AAAA, 32'd4_000_000_000, 32'd3_999_999_999,
                        32'd100_000_001, 32'd0, 32'd7};
        foreach (edge_values[i])
        begin
            send_value(edge_values[i]);
            if (i == 5)
                idle_burst();
        end
        wait_drained();

        // Random values with sender gaps
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_value(pick_value());
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            else if (i < RANDOM_ITEMS - STEADY_ITEMS && $urandom_range(0, 3) == 0)
                idle_burst();
        end
        start = 1'b0;

        // Drain pending digits, then let the block settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("binary_to_decimal_ascii_top_tb OK");
        else
            $display("binary_to_decimal_ascii_top_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
